/* sv/binary_clock_set_and_display_top_macros.svh */
// Assertion macros for the binary clock controller
`ifndef BINARY_CLOCK_SET_AND_DISPLAY_TOP_MACROS_SVH
`define BINARY_CLOCK_SET_AND_DISPLAY_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BCSD_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("bcsd assertion failed");
`define BCSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bcsd assertion failed");
`else
`define BCSD_ASSERT(lbl, expr)
`define BCSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/bcsd_pkg.sv */
package bcsd_pkg;

    localparam int LED_W = 12;

    typedef struct packed {
        logic       mode;
        logic       plus_button;
        logic       long_press;
        logic       short_press;
        logic [4:0] rtc_hours;
        logic [5:0] rtc_minutes;
        logic [5:0] rtc_seconds;
        logic [31:0] tick_ms;
    } t_in_item;

    typedef struct packed {
        logic [LED_W-1:0] led_levels;
        logic             rtc_write;
        logic [4:0]       write_hours;
        logic [5:0]       write_minutes;
        logic [1:0]       current_mode;
    } t_out_item;

    typedef enum logic [2:0] {
        MODE_RUN     = 3'b001,
        MODE_HOURS   = 3'b010,
        MODE_MINUTES = 3'b100
    } t_mode;

    localparam logic [1:0] CUR_RUN     = 2'd0;
    localparam logic [1:0] CUR_HOURS   = 2'd1;
    localparam logic [1:0] CUR_MINUTES = 2'd2;

    localparam logic [4:0] HOURS_DAY   = 5'd24;
    localparam logic [4:0] HOURS_MAX   = 5'd23;
    localparam logic [4:0] HOURS_HALF  = 5'd12;
    localparam logic [5:0] MINS_HOUR   = 6'd60;
    localparam logic [5:0] MINS_MAX    = 6'd59;

    localparam logic [LED_W-1:0] LED_ALL_DARK = '1;

    // floor(x/3) == (x * DIV3_RECIP) >> 33 for any 32-bit x
    localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;

endpackage

/* sv/bcsd_leds.sv */
module bcsd_leds
    import bcsd_pkg::*;
(
    input  logic [5:0]       i_minutes,
    input  logic [4:0]       i_hours,
    input  logic             i_seconds_lsb,
    output logic [LED_W-1:0] o_leds
);

    logic       pm;
    logic [4:0] h12;

    always_comb begin
        pm  = (i_hours >= HOURS_HALF);
        h12 = pm ? (i_hours - HOURS_HALF) : i_hours;
        o_leds[0] = ~i_seconds_lsb;
        for (int i = 0; i < 6; i++) begin
            o_leds[6-i] = ~i_minutes[i];
        end
        for (int i = 0; i < 4; i++) begin
            o_leds[7+i] = ~h12[i];
        end
        o_leds[11] = ~pm;
    end

endmodule

/* sv/binary_clock_set_and_display_top.sv */
// Data path: input register, then result register, from input transaction to result.
// Throughput: one transaction per cycle while the receiver does not stall; the only logic path is one 32x32 multiply
// for the blink phase plus small wraps and the LED encoder.
// Reset (synchronous, active low): mode run, edit and latched time zero,
// all LEDs dark, both pipeline registers empty.
`include "binary_clock_set_and_display_top_macros.svh"

module binary_clock_set_and_display_top
    import bcsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic             r_in_valid;
    t_in_item         r_in;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;
    t_mode            r_mode, n_mode;
    logic [4:0]       r_eh, n_eh, r_lh, n_lh;
    logic [5:0]       r_em, n_em, r_lm, n_lm;
    logic [LED_W-1:0] r_led, n_led;

    logic             adv, proc, phase;
    logic [63:0]      prod;
    logic [5:0]       eh_inc;
    logic [6:0]       em_inc;
    logic [4:0]       eh_up, eh_dn, eh_commit;
    logic [5:0]       em_up, em_dn, em_commit;
    logic [5:0]       d_minutes;
    logic [4:0]       d_hours;
    logic [LED_W-1:0] drawn;

    assign adv     = !r_out_valid || !i_stall;
    assign proc    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    assign prod  = {32'd0, r_in.tick_ms} * {32'd0, DIV3_RECIP};
    assign phase = prod[33];

    always_comb begin
        eh_inc    = {1'b0, r_eh} + 6'd1;
        eh_up     = (eh_inc >= {1'b0, HOURS_DAY}) ? 5'(eh_inc - {1'b0, HOURS_DAY})
                                                  : eh_inc[4:0];
        eh_dn     = (r_eh == 5'd0) ? HOURS_MAX : r_eh - 5'd1;
        eh_commit = (r_eh >= HOURS_DAY) ? r_eh - HOURS_DAY : r_eh;
        em_inc    = {1'b0, r_em} + 7'd1;
        em_up     = (em_inc >= {1'b0, MINS_HOUR}) ? 6'(em_inc - {1'b0, MINS_HOUR})
                                                  : em_inc[5:0];
        em_dn     = (r_em == 6'd0) ? MINS_MAX : r_em - 6'd1;
        em_commit = (r_em >= MINS_HOUR) ? r_em - MINS_HOUR : r_em;
    end

    always_comb begin
        case (r_mode)
            MODE_HOURS: begin
                d_minutes = r_em;
                d_hours   = phase ? r_eh : 5'd0;
            end
            MODE_MINUTES: begin
                d_minutes = phase ? r_em : 6'd0;
                d_hours   = r_eh;
            end
            default: begin
                d_minutes = r_in.rtc_minutes;
                d_hours   = r_in.rtc_hours;
            end
        endcase
    end

    bcsd_leds u_leds (
        .i_minutes     (d_minutes),
        .i_hours       (d_hours),
        .i_seconds_lsb (r_in.rtc_seconds[0]),
        .o_leds        (drawn)
    );

    always_comb begin
        n_mode = r_mode;
        n_eh   = r_eh;
        n_em   = r_em;
        n_lh   = r_lh;
        n_lm   = r_lm;
        n_led  = r_led;
        n_out  = r_out;
        n_out.rtc_write     = 1'b0;
        n_out.write_hours   = 5'd0;
        n_out.write_minutes = 6'd0;
        if (r_in.mode) begin
            n_lh = r_in.rtc_hours;
            n_lm = r_in.rtc_minutes;
            case (r_mode)
                MODE_RUN, MODE_HOURS, MODE_MINUTES: n_led = drawn;
                default: n_led = r_led;
            endcase
        end else if (r_in.long_press) begin
            if (r_in.plus_button) begin
                case (r_mode)
                    MODE_RUN: begin
                        n_eh   = r_lh;
                        n_em   = r_lm;
                        n_mode = MODE_HOURS;
                    end
                    MODE_HOURS: n_mode = MODE_MINUTES;
                    MODE_MINUTES: begin
                        n_mode = MODE_RUN;
                        n_lh   = eh_commit;
                        n_lm   = em_commit;
                        n_out.rtc_write     = 1'b1;
                        n_out.write_hours   = eh_commit;
                        n_out.write_minutes = em_commit;
                    end
                    default: n_mode = r_mode;
                endcase
            end else begin
                n_mode = MODE_RUN;
            end
        end else if (r_in.short_press) begin
            case (r_mode)
                MODE_HOURS:   n_eh = r_in.plus_button ? eh_up : eh_dn;
                MODE_MINUTES: n_em = r_in.plus_button ? em_up : em_dn;
                default: n_eh = r_eh;
            endcase
        end
        n_out.led_levels = n_led;
        case (n_mode)
            MODE_HOURS:   n_out.current_mode = CUR_HOURS;
            MODE_MINUTES: n_out.current_mode = CUR_MINUTES;
            default:      n_out.current_mode = CUR_RUN;
        endcase
        n_out_valid = proc ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_RUN;
            r_eh        <= '0;
            r_em        <= '0;
            r_lh        <= '0;
            r_lm        <= '0;
            r_led       <= LED_ALL_DARK;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            r_out_valid <= n_out_valid;
            if (proc) begin
                r_mode <= n_mode;
                r_eh   <= n_eh;
                r_em   <= n_em;
                r_lh   <= n_lh;
                r_lm   <= n_lm;
                r_led  <= n_led;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in <= i_data;
        end
        if (proc) begin
            r_out <= n_out;
        end
    end

    `BCSD_ASSERT(a_write_in_run, !(r_out_valid && r_out.rtc_write) || r_out.current_mode == CUR_RUN)
    `BCSD_ASSERT(a_write_range, !(r_out_valid && r_out.rtc_write) || (r_out.write_hours < HOURS_DAY && r_out.write_minutes < MINS_HOUR))
    `BCSD_ASSERT(a_write_zero, !(r_out_valid && !r_out.rtc_write) || (r_out.write_hours == 5'd0 && r_out.write_minutes == 6'd0))
    `BCSD_ASSERT_NEXT(a_state_hold, !proc, $stable(r_mode) && $stable(r_led) && $stable(r_eh) && $stable(r_em))
    `BCSD_ASSERT_NEXT(a_led_match, proc, r_out.led_levels == r_led)

endmodule

/* bench/tb_top.sv */
module tb_top
    import bcsd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ITEM_BUTTON  = 1'b0;
    localparam logic ITEM_REFRESH = 1'b1;
    localparam logic BTN_MINUS    = 1'b0;
    localparam logic BTN_PLUS     = 1'b1;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    binary_clock_set_and_display_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5ns i_clk = ~i_clk;

    t_in_item  event_q[$];
    t_out_item display_q[$];

    int   idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_go = 1'b0;
    bit   hold_off = 1'b0;
    logic in_taken = 1'b0;
    int   errors = 0;

    // predicted controller state
    logic [1:0]  set_mode = CUR_RUN;
    int          edit_h = 0;
    int          edit_m = 0;
    int          last_h = 0;
    int          last_m = 0;
    logic [11:0] led_reg = LED_ALL_DARK;

    task automatic note_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic logic [11:0] led_pattern(input int mins, input int hrs, input int secs);
        logic [11:0] leds;
        int h;
        int i;
        leds = '0;
        h = hrs;
        if (secs[0] == 1'b0) leds[0] = 1'b1;
        for (i = 0; i < 6; i++)
            if (mins[i] == 1'b0) leds[6 - i] = 1'b1;
        if (h >= int'(HOURS_HALF)) h -= int'(HOURS_HALF);
        else leds[11] = 1'b1;
        for (i = 0; i < 4; i++)
            if (h[i] == 1'b0) leds[7 + i] = 1'b1;
        return leds;
    endfunction

    task automatic clock_step(input t_in_item it);
        t_out_item   r;
        logic [31:0] third;
        bit          blink;
        r = '0;
        if (it.mode == ITEM_REFRESH) begin
            third = it.tick_ms / 32'd3;
            blink = third[0];
            last_h = int'(it.rtc_hours);
            last_m = int'(it.rtc_minutes);
            case (set_mode)
                CUR_RUN: led_reg = led_pattern(int'(it.rtc_minutes), int'(it.rtc_hours),
                                               int'(it.rtc_seconds));
                CUR_HOURS: led_reg = led_pattern(edit_m, blink ? edit_h : 0,
                                                 int'(it.rtc_seconds));
                CUR_MINUTES: led_reg = led_pattern(blink ? edit_m : 0, edit_h,
                                                   int'(it.rtc_seconds));
                default: ;
            endcase
        end else if (it.long_press) begin
            if (it.plus_button == BTN_PLUS) begin
                case (set_mode)
                    CUR_RUN: begin
                        edit_m = last_m;
                        edit_h = last_h;
                        set_mode = CUR_HOURS;
                    end
                    CUR_HOURS: set_mode = CUR_MINUTES;
                    CUR_MINUTES: begin
                        set_mode = CUR_RUN;
                        last_m = edit_m % int'(MINS_HOUR);
                        last_h = edit_h % int'(HOURS_DAY);
                        r.rtc_write = 1'b1;
                        r.write_hours = last_h[4:0];
                        r.write_minutes = last_m[5:0];
                    end
                    default: ;
                endcase
            end else begin
                set_mode = CUR_RUN;
            end
        end else if (it.short_press) begin
            if (set_mode == CUR_HOURS) begin
                if (it.plus_button == BTN_PLUS) edit_h = (edit_h + 1) % int'(HOURS_DAY);
                else edit_h = (edit_h == 0) ? int'(HOURS_MAX) : edit_h - 1;
            end else if (set_mode == CUR_MINUTES) begin
                if (it.plus_button == BTN_PLUS) edit_m = (edit_m + 1) % int'(MINS_HOUR);
                else edit_m = (edit_m == 0) ? int'(MINS_MAX) : edit_m - 1;
            end
        end
        r.led_levels = led_reg;
        r.current_mode = set_mode;
        display_q.push_back(r);
    endtask

    // monitor: predict on accepted input, check on accepted output
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            in_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) clock_step(i_data);
            if (o_valid && !i_stall) begin
                if (display_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected transaction %h", o_data));
                end else begin
                    want = display_q.pop_front();
                    if (o_data.led_levels !== want.led_levels)
                        note_mismatch($sformatf("led_levels got %03h want %03h",
                                                o_data.led_levels, want.led_levels));
                    if (o_data.rtc_write !== want.rtc_write)
                        note_mismatch($sformatf("rtc_write got %b want %b",
                                                o_data.rtc_write, want.rtc_write));
                    if (o_data.write_hours !== want.write_hours)
                        note_mismatch($sformatf("write_hours got %0d want %0d",
                                                o_data.write_hours, want.write_hours));
                    if (o_data.write_minutes !== want.write_minutes)
                        note_mismatch($sformatf("write_minutes got %0d want %0d",
                                                o_data.write_minutes, want.write_minutes));
                    if (o_data.current_mode !== want.current_mode)
                        note_mismatch($sformatf("current_mode got %0d want %0d",
                                                o_data.current_mode, want.current_mode));
                end
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (event_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_data <= event_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
    end

    // long receiver hold-off so the block backs up onto its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (100) @(posedge i_clk);
        hold_off = 1'b0;
    end

    function automatic t_in_item refresh_item(input int h, input int m, input int s,
                                              input logic [31:0] tick);
        t_in_item it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.mode = ITEM_REFRESH;
        it.rtc_hours = h[4:0];
        it.rtc_minutes = m[5:0];
        it.rtc_seconds = s[5:0];
        it.tick_ms = tick;
        return it;
    endfunction

    function automatic t_in_item button_item(input logic plus, input logic longp,
                                             input logic shortp);
        t_in_item it;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.mode = ITEM_BUTTON;
        it.plus_button = plus;
        it.long_press = longp;
        it.short_press = shortp;
        return it;
    endfunction

    task automatic make_random_events(input int n);
        int k;
        int pick;
        logic [63:0] raw;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                if ($urandom_range(0, 4) != 0)
                    event_q.push_back(refresh_item($urandom_range(0, 23), $urandom_range(0, 59),
                                                   $urandom_range(0, 59), $urandom));
                else
                    event_q.push_back(refresh_item($urandom_range(0, 31), $urandom_range(0, 63),
                                                   $urandom_range(0, 63), $urandom));
            end else if (pick < 55) begin
                event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'($urandom_range(0, 1))));
            end else if (pick < 62) begin
                event_q.push_back(button_item(BTN_MINUS, 1'b1, 1'($urandom_range(0, 1))));
            end else if (pick < 92) begin
                event_q.push_back(button_item(1'($urandom_range(0, 1)), 1'b0, 1'b1));
            end else begin
                raw = {$urandom, $urandom};
                event_q.push_back(raw[$bits(t_in_item)-1:0]);
            end
        end
    endtask

    task automatic wait_drained();
        while (event_q.size() != 0 || i_valid || display_q.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int p;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        event_q.push_back(refresh_item(0, 0, 0, 32'd0));
        event_q.push_back(refresh_item(23, 59, 59, 32'hFFFF_FFFF));
        event_q.push_back(refresh_item(12, 0, 1, 32'd3));
        event_q.push_back(refresh_item(31, 63, 63, 32'd5));
        event_q.push_back(button_item(BTN_PLUS, 1'b0, 1'b1));
        event_q.push_back(button_item(BTN_MINUS, 1'b0, 1'b0));
        event_q.push_back(refresh_item(0, 0, 2, 32'd0));
        event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'b0));
        event_q.push_back(button_item(BTN_MINUS, 1'b0, 1'b1));
        event_q.push_back(button_item(BTN_PLUS, 1'b0, 1'b1));
        event_q.push_back(refresh_item(5, 6, 7, 32'd3));
        event_q.push_back(refresh_item(5, 6, 8, 32'd2));
        event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'b1));
        event_q.push_back(button_item(BTN_MINUS, 1'b0, 1'b1));
        event_q.push_back(button_item(BTN_PLUS, 1'b0, 1'b1));
        event_q.push_back(refresh_item(5, 6, 9, 32'd4));
        event_q.push_back(refresh_item(5, 6, 9, 32'd1));
        event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'b0));
        event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'b0));
        event_q.push_back(button_item(BTN_MINUS, 1'b1, 1'b0));
        event_q.push_back(button_item(BTN_MINUS, 1'b1, 1'b0));
        event_q.push_back(refresh_item(31, 63, 0, 32'd3));
        event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'b0));
        event_q.push_back(button_item(BTN_PLUS, 1'b0, 1'b1));
        event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'b0));
        event_q.push_back(button_item(BTN_PLUS, 1'b0, 1'b1));
        event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'b0));
        event_q.push_back(refresh_item(30, 62, 0, 32'd0));
        event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'b0));
        event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'b0));
        event_q.push_back(button_item(BTN_PLUS, 1'b1, 1'b0));

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 76; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 76; end
                default: begin idle_pct = 36; stall_pct = 36; end
            endcase
            make_random_events(215);
            if (p == 0) begin
                repeat (40) @(posedge i_clk);
                hold_go = 1'b1;
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("binary_clock_set_and_display_top regression: pass");
        else
            $display("binary_clock_set_and_display_top regression: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("binary_clock_set_and_display_top regression: fail");
        $finish;
    end

endmodule
